@@ design/kwsc_pkg.sv @@
// shared constants and types for the keyword substitution cipher
package kwsc_pkg;

    localparam int unsigned ALPHABET = 26;
    localparam int unsigned LETTER_W = 5;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned CFG_IDX_W = 8;

    localparam logic [CHAR_W-1:0] LETTER_A = 8'd65;
    localparam logic [CHAR_W-1:0] LETTER_Z = 8'd90;
    localparam logic [CHAR_W-1:0] LOWER_A  = 8'd97;
    localparam logic [CHAR_W-1:0] LOWER_Z  = 8'd122;
    localparam logic [CHAR_W-1:0] CASE_GAP = 8'd32;

    localparam logic [1:0] OP_KEY    = 2'd0;
    localparam logic [1:0] OP_FINISH = 2'd1;
    localparam logic [1:0] OP_TEXT   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT   = 8'd1;

    localparam logic [LETTER_W-1:0] LAST_LETTER = 5'd25;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [CHAR_W-1:0]   t_char;

    // one binding of plaintext letter to cipher letter
    typedef struct packed {
        logic    en;
        t_letter plain;
        t_letter cipher;
    } t_bind_req;

endpackage

@@ design/kwsc_tables.sv @@
// forward and reverse substitution tables with bind write and text lookup
module kwsc_tables (
    input  logic               i_clk,
    input  kwsc_pkg::t_bind_req i_bind,
    input  logic               i_lookup_en,
    input  kwsc_pkg::t_letter  i_lookup_idx,
    input  logic               i_decrypt,
    output kwsc_pkg::t_letter  o_lookup
);
    import kwsc_pkg::*;

    t_letter r_forward [ALPHABET];
    t_letter r_reverse [ALPHABET];
    t_letter r_lookup;

    always_ff @(posedge i_clk) begin
        if (i_bind.en) begin
            r_forward[i_bind.plain]  <= i_bind.cipher;
            r_reverse[i_bind.cipher] <= i_bind.plain;
        end
    end

    // index is kept below ALPHABET by the caller
    always_ff @(posedge i_clk) begin
        if (i_lookup_en) begin
            r_lookup <= i_decrypt ? r_reverse[i_lookup_idx] : r_forward[i_lookup_idx];
        end
    end

    assign o_lookup = r_lookup;

endmodule

@@ design/keyword_substitution_cipher.sv @@
// keyword substitution cipher top level: keyword loading, table fill sequencer, text mapping
// keyword and text requests are handled in the idle state without a busy state; a text result is registered and shows
// the cycle after acceptance. a finish request walks the letters a..z through the shared
// bind unit, one letter a cycle, so the block stalls input requests until the walk ends.
// synchronous active-low reset clears the seen flags, counters, flags and config;
// the substitution tables are not reset and their lookups are used only after a finish.
module keyword_substitution_cipher (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // input request channel
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_opcode,
    input  kwsc_pkg::t_char              i_char_value,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output kwsc_pkg::t_char              o_mapped_char,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [kwsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  kwsc_pkg::t_char              i_cfg_data
);
    import kwsc_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic       r_state;
    t_letter    r_walk_idx;
    logic [255:0] r_seen;
    t_char      r_kept;
    t_letter    r_next_plain;
    logic       r_table_ready;
    logic       r_loading;
    logic       r_decrypt;
    t_char      r_limit;
    logic       r_out_valid;
    t_char      r_text_char;
    logic       r_text_map;

    logic       in_accept;
    logic       key_req;
    logic       fin_req;
    logic       text_req;
    t_char      up_char;
    logic       up_is_letter;
    logic       seen_eff;
    t_char      kept_eff;
    t_letter    next_eff;
    logic       keep_char;
    logic [255:0] n_seen;
    t_char      walk_char;
    logic       walk_bind;
    t_bind_req  bind_req;
    logic       text_is_letter;
    t_char      text_off;
    t_letter    lookup_idx;
    t_letter    lookup_val;

    // handshakes
    assign o_in_stall  = (r_state == ST_WALK) || (r_out_valid && i_out_stall);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign key_req     = in_accept && (i_opcode == OP_KEY);
    assign fin_req     = in_accept && (i_opcode == OP_FINISH);
    assign text_req    = in_accept && (i_opcode == OP_TEXT);
    assign o_cfg_ready = 1'b1;

    // upper-case the keyword character, only a..z change
    always_comb begin
        up_char = i_char_value;
        if (i_char_value >= LOWER_A && i_char_value <= LOWER_Z) begin
            up_char = i_char_value - CASE_GAP;
        end
    end
    assign up_is_letter = (up_char >= LETTER_A) && (up_char <= LETTER_Z);

    // a keyword request outside loading sees the freshly cleared state
    assign seen_eff  = r_loading ? r_seen[up_char] : 1'b0;
    assign kept_eff  = r_loading ? r_kept : '0;
    assign next_eff  = r_loading ? r_next_plain : '0;
    assign keep_char = !seen_eff && (kept_eff < r_limit);

    // seen set after a keyword request, starting from empty on a new keyword
    always_comb begin
        n_seen = r_loading ? r_seen : '0;
        if (keep_char) begin
            n_seen[up_char] = 1'b1;
        end
    end

    // fill walk reads the seen flag of the current letter
    assign walk_char = LETTER_A + {3'b000, r_walk_idx};
    assign walk_bind = (r_state == ST_WALK) && !r_seen[walk_char];

    // shared bind unit request: keyword letter or walk letter
    always_comb begin
        bind_req = '0;
        if (r_state == ST_WALK) begin
            bind_req.en     = walk_bind && (r_next_plain <= LAST_LETTER);
            bind_req.plain  = r_next_plain;
            bind_req.cipher = r_walk_idx;
        end else begin
            bind_req.en     = key_req && keep_char && up_is_letter &&
                              (next_eff <= LAST_LETTER);
            bind_req.plain  = next_eff;
            bind_req.cipher = t_letter'(up_char - LETTER_A);
        end
    end

    // text lookup, table read registered at acceptance
    assign text_is_letter = (i_char_value >= LETTER_A) && (i_char_value <= LETTER_Z);
    assign text_off       = i_char_value - LETTER_A;
    assign lookup_idx     = text_is_letter ? text_off[LETTER_W-1:0] : '0;

    kwsc_tables u_tables (
        .i_clk       (i_clk),
        .i_bind      (bind_req),
        .i_lookup_en (text_req),
        .i_lookup_idx(lookup_idx),
        .i_decrypt   (r_decrypt),
        .o_lookup    (lookup_val)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decrypt <= 1'b0;
            r_limit   <= 8'd255;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DECRYPT: r_decrypt <= i_cfg_data[0];
                CFG_LIMIT:   r_limit   <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // sequencer and keyword state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_walk_idx    <= '0;
            r_seen        <= '0;
            r_kept        <= '0;
            r_next_plain  <= '0;
            r_table_ready <= 1'b0;
            r_loading     <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (key_req) begin
                        // first keyword character starts a new keyword
                        if (!r_loading) begin
                            r_table_ready <= 1'b0;
                            r_loading     <= 1'b1;
                        end
                        r_seen       <= n_seen;
                        r_kept       <= keep_char ? kept_eff + 8'd1 : kept_eff;
                        r_next_plain <= bind_req.en ? next_eff + 5'd1 : next_eff;
                    end else if (fin_req) begin
                        // finish without keyword starts from an empty one
                        if (!r_loading) begin
                            r_seen        <= '0;
                            r_kept        <= '0;
                            r_next_plain  <= '0;
                            r_table_ready <= 1'b0;
                        end
                        r_walk_idx <= '0;
                        r_state    <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (bind_req.en) begin
                        r_next_plain <= r_next_plain + 5'd1;
                    end
                    if (r_walk_idx == LAST_LETTER) begin
                        r_loading     <= 1'b0;
                        r_table_ready <= 1'b1;
                        r_state       <= ST_IDLE;
                    end else begin
                        r_walk_idx <= r_walk_idx + 5'd1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (text_req) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // raw character and whether the table applies, held with the lookup
    always_ff @(posedge i_clk) begin
        if (text_req) begin
            r_text_char <= i_char_value;
            r_text_map  <= r_table_ready && text_is_letter;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mapped_char = r_text_map ? (LETTER_A + {3'b000, lookup_val}) : r_text_char;

endmodule
